// File: sv/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
// Used by the channel interfaces, the controller, the datapath and the top level.
package salc_pkg;

	localparam int REQ_TYPE_W  = 2;
	localparam int ADDR_FIELD_W = 64;
	localparam int WAY_OUT_W   = 3;
	localparam int CNT_W       = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 6;

	// request kinds; anything but modify is one access
	localparam logic [REQ_TYPE_W-1:0] REQ_MODIFY = 2'd2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_BLOCK_BITS = 2'd1,
		CFG_WAYS_USED  = 2'd2
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic clear_step;   // write one zero row of the clearing sweep
		logic capture;      // latch the request beat
		logic lookup;       // form set/tag and read the set row
		logic update;       // resolve, write row back, load result register
		logic last_access;  // result of this update ends the request
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_done;   // sweep is on its last row
		logic is_modify;    // captured request makes two accesses
		logic out_free;     // result register can take a beat
	} dp_sts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (&c) ? c : c + 1'b1;
	endfunction

endpackage

// File: sv/salc_if.sv
// Valid/ready channel interfaces for request and result beats.
// Depends on salc_pkg for the field widths.
interface salc_req_if;
	logic                                valid;
	logic                                ready;
	logic [salc_pkg::REQ_TYPE_W-1:0]     req_type;
	logic [salc_pkg::ADDR_FIELD_W-1:0]   address;

	modport source (output valid, req_type, address, input ready);
	modport sink (input valid, req_type, address, output ready);
endinterface

interface salc_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              hit;
	logic                              evicted;
	logic [salc_pkg::WAY_OUT_W-1:0]    way;
	logic [salc_pkg::CNT_W-1:0]        hits_total;
	logic [salc_pkg::CNT_W-1:0]        misses_total;
	logic [salc_pkg::CNT_W-1:0]        evictions_total;
	logic                              last;

	modport source (output valid, hit, evicted, way, hits_total, misses_total,
		evictions_total, last, input ready);
	modport sink (input valid, hit, evicted, way, hits_total, misses_total,
		evictions_total, last, output ready);
endinterface

// File: sv/salc_ctrl.sv
// Controller FSM: clearing sweep, request accept, lookup and update sequencing.
// Depends on salc_pkg for the command and status structs.
module salc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output salc_pkg::dp_cmd_t cmd,
	input  salc_pkg::dp_sts_t sts
);

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_READ   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   second_q, second_d;
	logic   more;

	// a modify needs a second pass after its first update
	assign more = sts.is_modify && !second_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d  = state_q;
		second_d = second_q;
		cmd      = '0;
		cmd.last_access = !more;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_done) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					second_d    = 1'b0;
					state_d     = ST_READ;
				end
			end
			ST_READ: begin
				cmd.lookup = 1'b1;
				state_d    = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (sts.out_free) begin
					cmd.update = 1'b1;
					if (more) begin
						second_d = 1'b1;
						state_d  = ST_READ;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

endmodule

// File: sv/salc_dp.sv
// Datapath: config registers, set row memory, tag compare, LRU age update,
// hit/miss/eviction counters and the result register. Depends on salc_pkg, salc_rsp_if.
module salc_dp #(
	parameter int MAX_SET_BITS = 10,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [salc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [salc_pkg::REQ_TYPE_W-1:0]     req_type,
	input  logic [salc_pkg::ADDR_FIELD_W-1:0]   address,
	input  salc_pkg::dp_cmd_t                   cmd,
	output salc_pkg::dp_sts_t                   sts,
	salc_rsp_if.source                          rsp
);

	localparam int SETS  = 1 << MAX_SET_BITS;
	localparam int AGE_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int WAY_W = AGE_W;
	localparam int SH_W  = 8;
	localparam int WOW   = salc_pkg::WAY_OUT_W;
	localparam int CW    = salc_pkg::CNT_W;
	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

	typedef struct packed {
		logic [MAX_WAYS-1:0]                 valid;
		logic [MAX_WAYS-1:0][AGE_W-1:0]      age;
		logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tag;
	} row_t;

	// configuration
	logic [3:0] set_bits_q;
	logic [5:0] block_bits_q;
	logic [3:0] ways_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= 4'd4;
			block_bits_q <= 6'd4;
			ways_used_q  <= 4'd1;
		end else if (cfg_we) begin
			case (salc_pkg::cfg_reg_t'(cfg_index))
				salc_pkg::CFG_SET_BITS:   set_bits_q   <= cfg_data[3:0];
				salc_pkg::CFG_BLOCK_BITS: block_bits_q <= cfg_data[5:0];
				salc_pkg::CFG_WAYS_USED:  ways_used_q  <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// request capture
	logic [ADDR_WIDTH-1:0] addr_q;
	logic                  modify_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q   <= address[ADDR_WIDTH-1:0];
			modify_q <= (req_type == salc_pkg::REQ_MODIFY);
		end
	end

	// set index and tag
	logic [4:0]              sb_eff;
	logic [SH_W-1:0]         sh_set, sh_tag;
	logic [ADDR_WIDTH-1:0]   set_src, tag_c;
	logic [MAX_SET_BITS-1:0] set_mask, set_c;

	always_comb begin
		sb_eff = ({1'b0, set_bits_q} > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
			: {1'b0, set_bits_q};
		sh_set = SH_W'(block_bits_q);
		sh_tag = SH_W'(block_bits_q) + SH_W'(sb_eff);
		set_src = (sh_set >= SH_W'(ADDR_WIDTH)) ? '0 : (addr_q >> sh_set);
		tag_c   = (sh_tag >= SH_W'(ADDR_WIDTH)) ? '0 : (addr_q >> sh_tag);
		for (int i = 0; i < MAX_SET_BITS; i++) set_mask[i] = (5'(i) < sb_eff);
		set_c = set_src[MAX_SET_BITS-1:0] & set_mask;
	end

	// ways in use
	logic [4:0]          wu5, ways_eff;
	logic [MAX_WAYS-1:0] use_w;

	always_comb begin
		wu5      = (ways_used_q == 4'd0) ? 5'd1 : {1'b0, ways_used_q};
		ways_eff = (wu5 > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : wu5;
		for (int w = 0; w < MAX_WAYS; w++) use_w[w] = (5'(w) < ways_eff);
	end

	// clearing sweep counter
	logic [MAX_SET_BITS-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear_step) clr_q <= clr_q + 1'b1;
	end

	// set row memory, one row per set
	row_t                    mem [SETS];
	row_t                    row_q, new_row;
	logic [MAX_SET_BITS-1:0] set_q;
	logic [ADDR_WIDTH-1:0]   tag_q;

	always_ff @(posedge clk) begin
		if (cmd.clear_step) mem[clr_q] <= '0;
		else if (cmd.update) mem[set_q] <= new_row;
		if (cmd.lookup) begin
			row_q <= mem[set_c];
			set_q <= set_c;
			tag_q <= tag_c;
		end
	end

	// hit search, free way, LRU victim, age update
	logic             hit_c, free_c, evict_c;
	logic [WAY_W-1:0] hw, free_w, vic, tw;
	logic [AGE_W-1:0] oldest, ha;

	always_comb begin
		new_row = row_q;
		hit_c   = 1'b0;
		free_c  = 1'b0;
		hw      = '0;
		free_w  = '0;
		vic     = '0;
		oldest  = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (use_w[w] && row_q.valid[w] && (row_q.tag[w] == tag_q)) begin
				hit_c = 1'b1;
				hw    = WAY_W'(w);
			end
			if (use_w[w] && !row_q.valid[w]) begin
				free_c = 1'b1;
				free_w = WAY_W'(w);
			end
		end
		// ties go to the highest way
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (use_w[w] && (row_q.age[w] >= oldest)) begin
				oldest = row_q.age[w];
				vic    = WAY_W'(w);
			end
		end
		ha      = row_q.age[hw];
		evict_c = !hit_c && !free_c;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (use_w[w] && (row_q.age[w] != AGE_MAX)) begin
				if (hit_c) begin
					if (row_q.valid[w] && (row_q.age[w] < ha))
						new_row.age[w] = row_q.age[w] + 1'b1;
				end else if (free_c) begin
					if (row_q.valid[w]) new_row.age[w] = row_q.age[w] + 1'b1;
				end else begin
					new_row.age[w] = row_q.age[w] + 1'b1;
				end
			end
		end
		tw = hit_c ? hw : (free_c ? free_w : vic);
		new_row.age[tw] = '0;
		if (!hit_c) begin
			new_row.tag[tw]   = tag_q;
			new_row.valid[tw] = 1'b1;
		end
	end

	// counters and result register
	logic [CW-1:0] hits_q, misses_q, evicts_q;
	logic [CW-1:0] hits_n, misses_n, evicts_n;
	logic          out_valid_q;
	logic          hit_q, evicted_q, last_q;
	logic [WOW-1:0] way_q;

	assign hits_n   = hit_c ? salc_pkg::sat_inc(hits_q) : hits_q;
	assign misses_n = hit_c ? misses_q : salc_pkg::sat_inc(misses_q);
	assign evicts_n = evict_c ? salc_pkg::sat_inc(evicts_q) : evicts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q      <= '0;
			misses_q    <= '0;
			evicts_q    <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			hits_q      <= hits_n;
			misses_q    <= misses_n;
			evicts_q    <= evicts_n;
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			hit_q     <= hit_c;
			evicted_q <= evict_c;
			way_q     <= WOW'(tw);
			last_q    <= cmd.last_access;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.hit             = hit_q;
	assign rsp.evicted         = evicted_q;
	assign rsp.way             = way_q;
	assign rsp.hits_total      = hits_q;
	assign rsp.misses_total    = misses_q;
	assign rsp.evictions_total = evicts_q;
	assign rsp.last            = last_q;

	assign sts.clear_done = &clr_q;
	assign sts.is_modify  = modify_q;
	assign sts.out_free   = !out_valid_q || rsp.ready;

	a_no_update_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.clear_step && (cmd.update || cmd.lookup)))
		else $error("row write from sweep and access in the same cycle");

	a_update_into_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |-> (!out_valid_q || rsp.ready))
		else $error("result register overwritten before its beat was taken");

	a_valid_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.update))
		else $error("result beat appeared without an update");

	a_one_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && !(&hits_q) && !(&misses_q) |=>
		((hits_q != $past(hits_q)) != (misses_q != $past(misses_q))))
		else $error("access must bump exactly one of hit or miss count");

endmodule

// File: sv/set_assoc_lru_cache_model.sv
// Tag-only set-associative cache with true LRU. A request beat is captured, its set
// row is read into a register, then compared and updated into the result register;
// a modify repeats the row read and update for its second beat. An update waits
// while the result register still holds a beat not taken; a new request beat is
// taken only in idle. After arst_n a clearing sweep writes all 2^MAX_SET_BITS rows
// before the first request beat is taken; config writes work throughout.
module set_assoc_lru_cache_model #(
	parameter int MAX_SET_BITS = 10,
	parameter int MAX_WAYS     = 8,
	parameter int ADDR_WIDTH   = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [salc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [salc_pkg::CFG_DATA_W-1:0]  cfg_data,
	salc_req_if.sink                         req,
	salc_rsp_if.source                       rsp
);

	salc_pkg::dp_cmd_t cmd;
	salc_pkg::dp_sts_t sts;

	salc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	salc_dp #(
		.MAX_SET_BITS (MAX_SET_BITS),
		.MAX_WAYS     (MAX_WAYS),
		.ADDR_WIDTH   (ADDR_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_type  (req.req_type),
		.address   (req.address),
		.cmd       (cmd),
		.sts       (sts),
		.rsp       (rsp)
	);

endmodule
